/* rtl/wsmt_pkg.sv */
// wsmt_pkg: shared constants and types for the word set membership table.
// No dependencies.
package wsmt_pkg;

	localparam int DEPTH = 64;
	localparam int WORD_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LIM_W = 7;
	localparam int OUT_CNT_W = 7;
	localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_TEST = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_PRESENT = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;
	localparam logic [1:0] STATUS_ABSENT = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

endpackage

/* rtl/wsmt_cell.sv */
// wsmt_cell: one slot of the table; holds a word, compares it, shifts with neighbors.
// Depends on wsmt_pkg.
module wsmt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsmt_pkg::cell_ctrl_t          ctrl,
	input  logic [wsmt_pkg::WORD_W-1:0]   word_left,
	input  logic [wsmt_pkg::WORD_W-1:0]   word_right,
	input  logic [wsmt_pkg::WORD_W-1:0]   word_head,
	input  logic                          hit_right,
	input  logic [wsmt_pkg::WORD_W-1:0]   cmp_word,
	input  logic                          cmp_en,
	input  logic                          valid,
	output logic [wsmt_pkg::WORD_W-1:0]   word_q,
	output logic                          hit_s1
);

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			word_q <= word_left;
		end else if (ctrl.shift_down) begin
			word_q <= hit_right ? word_head : word_right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (cmp_en) begin
			hit_s1 <= valid && (word_q == cmp_word);
		end
	end

endmodule

/* rtl/word_set_membership_table.sv */
// word_set_membership_table: set of distinct words in a row of shifting cells.
// Depends on wsmt_pkg and wsmt_cell.
//
//   channel   handshake          payload
//   command   start / busy       operation, item_word
//   result    done (strobe)      status, found, entry_count
//   config    limit_we           limit_wdata
//
// The cells compare the word as a command is accepted; ST_EXEC then decides and
// shifts the cell row. The result strobes in the cycle after, while the next
// command may already be taken. busy is high for the decide cycle only.
// Reset clears the count (empty set) and sets the limit to 64.
// The receiver cannot stall; each result is shown for exactly one cycle.
module word_set_membership_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       operation,
	input  logic [wsmt_pkg::WORD_W-1:0]      item_word,
	input  logic                             limit_we,
	input  logic [wsmt_pkg::LIM_W-1:0]       limit_wdata,
	output logic                             done,
	output logic [1:0]                       status,
	output logic                             found,
	output logic [wsmt_pkg::OUT_CNT_W-1:0]   entry_count
);

	wsmt_pkg::state_t state_q, state_next;
	logic [wsmt_pkg::LIM_W-1:0] limit_q;
	logic [wsmt_pkg::CNT_W-1:0] count_q, count_next;
	logic [1:0] op_s1;
	logic [wsmt_pkg::WORD_W-1:0] word_s1;
	logic accept;
	logic present;
	logic [1:0] status_next;
	logic [wsmt_pkg::CMP_W-1:0] eff_limit, count_ext, lim_ext;
	wsmt_pkg::cell_ctrl_t ctrl;
	logic [wsmt_pkg::WORD_W-1:0] words [wsmt_pkg::DEPTH];
	logic [wsmt_pkg::DEPTH-1:0] hits;
	logic [wsmt_pkg::DEPTH-1:0] valids;

	assign accept = start && (state_q == wsmt_pkg::ST_IDLE);
	assign present = |hits;
	assign count_ext = wsmt_pkg::CMP_W'(count_q);
	assign lim_ext = wsmt_pkg::CMP_W'(limit_q);
	assign eff_limit = (lim_ext > wsmt_pkg::CMP_W'(wsmt_pkg::DEPTH)) ?
		wsmt_pkg::CMP_W'(wsmt_pkg::DEPTH) : lim_ext;

	always_comb begin
		state_next = state_q;
		case (state_q)
			wsmt_pkg::ST_IDLE: begin
				if (start) begin
					state_next = wsmt_pkg::ST_EXEC;
				end
			end
			wsmt_pkg::ST_EXEC: begin
				state_next = wsmt_pkg::ST_IDLE;
			end
			default: begin
				state_next = wsmt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q == wsmt_pkg::ST_EXEC);
		ctrl = '0;
		count_next = count_q;
		status_next = present ? wsmt_pkg::STATUS_OK : wsmt_pkg::STATUS_ABSENT;
		case (op_s1)
			wsmt_pkg::OP_ADD: begin
				if (present) begin
					status_next = wsmt_pkg::STATUS_PRESENT;
				end else if (count_ext >= eff_limit) begin
					status_next = wsmt_pkg::STATUS_FULL;
				end else begin
					status_next = wsmt_pkg::STATUS_OK;
					ctrl.shift_up = busy;
					count_next = count_q + wsmt_pkg::CNT_W'(1);
				end
			end
			wsmt_pkg::OP_REMOVE: begin
				if (present) begin
					status_next = wsmt_pkg::STATUS_OK;
					ctrl.shift_down = busy;
					count_next = count_q - wsmt_pkg::CNT_W'(1);
				end
			end
			wsmt_pkg::OP_TEST: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsmt_pkg::ST_IDLE;
			limit_q <= wsmt_pkg::LIMIT_RESET;
			count_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_next;
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
			if (busy) begin
				count_q <= count_next;
			end
			done <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= operation;
			word_s1 <= item_word;
		end
		if (busy) begin
			status <= status_next;
			found <= present;
			entry_count <= wsmt_pkg::OUT_CNT_W'(count_next);
		end
	end

	for (genvar k = 0; k < wsmt_pkg::DEPTH; k++) begin : g_cell
		logic [wsmt_pkg::WORD_W-1:0] left_w, right_w;
		logic right_hit;

		assign valids[k] = wsmt_pkg::CNT_W'(k) < count_q;

		if (k == 0) begin : g_head
			assign left_w = word_s1;
		end else begin : g_body
			assign left_w = words[k-1];
		end

		if (k == wsmt_pkg::DEPTH - 1) begin : g_tail
			assign right_w = words[k];
			assign right_hit = 1'b0;
		end else begin : g_mid
			assign right_w = words[k+1];
			assign right_hit = hits[k+1];
		end

		wsmt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.word_left  (left_w),
			.word_right (right_w),
			.word_head  (words[0]),
			.hit_right  (right_hit),
			.cmp_word   (item_word),
			.cmp_en     (accept),
			.valid      (valids[k]),
			.word_q     (words[k]),
			.hit_s1     (hits[k])
		);
	end

endmodule

/* rtl/wsmt_checker.sv */
// wsmt_checker: port-level assertions for word_set_membership_table, bound to it.
// Depends on wsmt_pkg.
module wsmt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [1:0]                       status,
	input logic                             found,
	input logic [wsmt_pkg::OUT_CNT_W-1:0]   entry_count
);

	a_beat_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 done)
		else $error("result beat not two cycles after command");

	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_done_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == wsmt_pkg::STATUS_FULL || status == wsmt_pkg::STATUS_ABSENT))
		|-> !found)
		else $error("found set with a miss status");

	a_present_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == wsmt_pkg::STATUS_PRESENT) |-> (found && entry_count != '0))
		else $error("already-present result without a held word");

endmodule

bind word_set_membership_table wsmt_checker u_wsmt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found       (found),
	.entry_count (entry_count)
);

/* tb/word_set_membership_table_tb.sv */
// word_set_membership_table_tb: self-checking bench for the word set table.
// Keeps its own copy of the set and count, predicts every beat, checks results.
// Depends on wsmt_pkg and word_set_membership_table.
module word_set_membership_table_tb;
	import wsmt_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]           status;
		logic                 found;
		logic [OUT_CNT_W-1:0] count;
	} table_reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           operation;
	logic [WORD_W-1:0]    item_word;
	logic                 limit_we;
	logic [LIM_W-1:0]     limit_wdata;
	logic                 done;
	logic [1:0]           status;
	logic                 found;
	logic [OUT_CNT_W-1:0] entry_count;

	logic [WORD_W-1:0] model_words [DEPTH];
	int                model_count;
	int                model_limit;
	table_reply_t      pending_replies [$];
	table_reply_t      reply_head;
	logic [WORD_W-1:0] word_pool [96];
	int                error_count;

	word_set_membership_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.item_word  (item_word),
		.limit_we   (limit_we),
		.limit_wdata(limit_wdata),
		.done       (done),
		.status     (status),
		.found      (found),
		.entry_count(entry_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic table_reply_t predict_table_op(input logic [1:0] op,
			input logic [WORD_W-1:0] word);
		int slot;
		int cap;
		table_reply_t r;
		slot = -1;
		for (int k = 0; k < model_count; k++)
			if (slot < 0 && model_words[k] == word)
				slot = k;
		cap = (model_limit > DEPTH) ? DEPTH : model_limit;
		r.found = (slot >= 0);
		case (op)
			OP_ADD: begin
				if (r.found)
					r.status = STATUS_PRESENT;
				else if (model_count >= cap)
					r.status = STATUS_FULL;
				else begin
					model_words[model_count] = word;
					model_count++;
					r.status = STATUS_OK;
				end
			end
			OP_REMOVE: begin
				if (r.found) begin
					model_count--;
					model_words[slot] = model_words[model_count];
					r.status = STATUS_OK;
				end else
					r.status = STATUS_ABSENT;
			end
			default: r.status = r.found ? STATUS_OK : STATUS_ABSENT;
		endcase
		r.count = OUT_CNT_W'(model_count);
		return r;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] word);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		item_word <= word;
		do @(posedge clk); while (busy);
		pending_replies.push_back(predict_table_op(op, word));
	endtask

	task automatic idle_gap(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_table_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input int value);
		wait_table_idle();
		@(negedge clk);
		limit_we <= 1'b1;
		limit_wdata <= LIM_W'(value);
		@(negedge clk);
		limit_we <= 1'b0;
		model_limit = value;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("result beat with no command outstanding");
				error_count++;
			end else begin
				reply_head = pending_replies.pop_front();
				if (status !== reply_head.status) begin
					$error("status: expected %0d, actual %0d", reply_head.status, status);
					error_count++;
				end
				if (found !== reply_head.found) begin
					$error("found: expected %0d, actual %0d", reply_head.found, found);
					error_count++;
				end
				if (entry_count !== reply_head.count) begin
					$error("entry_count: expected %0d, actual %0d",
						reply_head.count, entry_count);
					error_count++;
				end
			end
		end
	end

	task automatic test_basic_ops();
		send_item(OP_TEST, 32'h0000_0000);
		send_item(OP_REMOVE, 32'h0000_0005);
		send_item(OP_ADD, 32'h0000_0000);
		send_item(OP_ADD, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'h0000_0000);
		send_item(OP_ADD, 32'h1234_5678);
		send_item(OP_ADD, 32'hA5A5_A5A5);
		send_item(OP_TEST, 32'hFFFF_FFFF);
		send_item(OP_SPARE, 32'h0000_0000);
		send_item(OP_SPARE, 32'h5A5A_5A5A);
		// middle entry removed; the bench model moves its last entry into the freed slot
		send_item(OP_REMOVE, 32'hFFFF_FFFF);
		send_item(OP_TEST, 32'hA5A5_A5A5);
		send_item(OP_REMOVE, 32'hA5A5_A5A5);
		send_item(OP_REMOVE, 32'h1234_5678);
		send_item(OP_REMOVE, 32'h0000_0000);
		send_item(OP_REMOVE, 32'h0000_0000);
	endtask

	task automatic test_limit_cases();
		write_limit(2);
		send_item(OP_ADD, 32'h0000_0001);
		send_item(OP_ADD, 32'h0000_0002);
		send_item(OP_ADD, 32'h0000_0003);
		// limit below count
		write_limit(1);
		send_item(OP_ADD, 32'h0000_0004);
		send_item(OP_ADD, 32'h0000_0001);
		send_item(OP_REMOVE, 32'h0000_0001);
		send_item(OP_ADD, 32'h0000_0004);
		send_item(OP_REMOVE, 32'h0000_0002);
		send_item(OP_ADD, 32'h0000_0004);
		write_limit(0);
		send_item(OP_ADD, 32'h0000_0005);
		send_item(OP_ADD, 32'h0000_0004);
		send_item(OP_TEST, 32'h0000_0004);
		send_item(OP_REMOVE, 32'h0000_0004);
		send_item(OP_ADD, 32'h8000_0000);
	endtask

	task automatic test_fill_to_depth();
		// limit above depth acts as depth
		write_limit(127);
		for (int i = 0; i < DEPTH; i++)
			send_item(OP_ADD, {i[15:0], ~i[15:0]});
		send_item(OP_ADD, 32'hDEAD_0001);
		send_item(OP_ADD, {16'd7, ~16'd7});
		write_limit(65);
		send_item(OP_ADD, 32'hDEAD_0002);
		send_item(OP_TEST, {16'd63, ~16'd63});
		while (model_count > 0)
			send_item(OP_REMOVE, model_words[$urandom_range(0, model_count - 1)]);
	endtask

	function automatic logic [WORD_W-1:0] pick_word(input int pool_size);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return $urandom;
		if (r < 20)
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'h0000_0001;
			endcase
		if (r < 45 && model_count > 0)
			return model_words[$urandom_range(0, model_count - 1)];
		return word_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	task automatic run_phase(input int limit, input int pool_size, input int add_weight,
			input int items, input bit gaps);
		logic [1:0] op;
		int r;
		write_limit(limit);
		for (int i = 0; i < items; i++) begin
			if (gaps && (i % 32) < 20 && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 10));
			if ($urandom_range(0, 99) < add_weight)
				op = OP_ADD;
			else begin
				r = $urandom_range(0, 19);
				op = (r < 9) ? OP_REMOVE : (r < 17) ? OP_TEST : OP_SPARE;
			end
			send_item(op, pick_word(pool_size));
		end
	endtask

	task automatic test_random_traffic();
		foreach (word_pool[i])
			word_pool[i] = $urandom;
		run_phase(64, 16, 40, 40, 1'b1);
		run_phase(127, 96, 65, 50, 1'b1);
		run_phase(8, 24, 45, 40, 1'b1);
		run_phase(1, 6, 40, 25, 1'b1);
		run_phase(0, 8, 40, 20, 1'b1);
		run_phase($urandom_range(1, 127), 48, 50, 40, 1'b1);
		run_phase(64, 40, 35, 70, 1'b0);
	endtask

	initial begin
		error_count = 0;
		model_count = 0;
		model_limit = LIMIT_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ADD;
		item_word = '0;
		limit_we = 1'b0;
		limit_wdata = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_limit_cases();
		test_fill_to_depth();
		test_random_traffic();

		wait_table_idle();
		repeat (8) @(negedge clk);
		if (error_count == 0)
			$display("word_set_membership_table test passed");
		else
			$display("word_set_membership_table test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("word_set_membership_table test failed");
		$finish;
	end

endmodule

/* word_set_membership_table.f */
rtl/wsmt_pkg.sv
rtl/wsmt_cell.sv
rtl/word_set_membership_table.sv
rtl/wsmt_checker.sv
tb/word_set_membership_table_tb.sv
